// ===== hdl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared codes for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;
   // branch codes as reported on the result channel
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_M00   = 2'd1;
   localparam logic [1:0] BR_M11   = 2'd2;
   localparam logic [1:0] BR_M22   = 2'd3;
endpackage
`default_nettype wire

// ===== hdl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Branch choice, square root argument and numerators, one register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_front
   import rmq_pkg::*;
#(
   parameter int W  = 16,
   parameter int F  = 14,
   parameter int AW = 20,
   parameter int UW = 19,
   parameter int NW = 17
) (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
   output logic [UW-1:0]            arg_ff,
   output logic [NW-1:0]            n0_ff, n1_ff, n2_ff,
   output logic [2:0]               neg_ff,
   output logic [1:0]               br_ff
);
   localparam logic signed [AW-1:0] ONE_A = AW'(1) << F;

   logic signed [AW-1:0] a00, a11, a22, tr, arg;
   logic signed [W:0]    d_x, d_y, d_z, s_xy, s_xz, s_yz;
   logic signed [W:0]    n0, n1, n2;
   logic [UW-1:0]        arg_in;
   logic [NW-1:0]        n0_in, n1_in, n2_in;
   logic [2:0]           neg_in;
   logic [1:0]           br_in;

   assign a00 = AW'(m00);
   assign a11 = AW'(m11);
   assign a22 = AW'(m22);
   assign tr  = a00 + a11 + a22;

   // element sums and differences
   assign d_x  = (W+1)'(m21) - (W+1)'(m12);
   assign d_y  = (W+1)'(m02) - (W+1)'(m20);
   assign d_z  = (W+1)'(m10) - (W+1)'(m01);
   assign s_xy = (W+1)'(m01) + (W+1)'(m10);
   assign s_xz = (W+1)'(m02) + (W+1)'(m20);
   assign s_yz = (W+1)'(m12) + (W+1)'(m21);

   // branch choice; the numerators fill the non-quarter slots in order
   always_comb begin
      if (tr > 0) begin
         br_in = BR_TRACE; arg = tr + ONE_A;
         n0 = d_x; n1 = d_y; n2 = d_z;
      end else if (m00 > m11 && m00 > m22) begin
         br_in = BR_M00; arg = ONE_A + a00 - a11 - a22;
         n0 = s_xy; n1 = s_xz; n2 = d_x;
      end else if (m11 > m22) begin
         br_in = BR_M11; arg = ONE_A + a11 - a00 - a22;
         n0 = s_xy; n1 = s_yz; n2 = d_y;
      end else begin
         br_in = BR_M22; arg = ONE_A + a22 - a00 - a11;
         n0 = s_xz; n1 = s_yz; n2 = d_z;
      end
      arg_in = arg[AW-1] ? '0 : arg[UW-1:0];
      neg_in = {n2[W], n1[W], n0[W]};
      n0_in  = n0[W] ? NW'(-n0) : NW'(n0);
      n1_in  = n1[W] ? NW'(-n1) : NW'(n1);
      n2_in  = n2[W] ? NW'(-n2) : NW'(n2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg_ff <= arg_in;
         n0_ff  <= n0_in;
         n1_ff  <= n1_in;
         n2_ff  <= n2_in;
         neg_ff <= neg_in;
         br_ff  <= br_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_sqrt #(
   parameter int VW = 34,
   parameter int RW = 17
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [VW-1:0] v,
   output logic [RW-1:0]      root
);
   logic [RW+1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [VW-1:0] rest_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW+1:0] src_rem, rem_t, trial, rem_in;
      logic [RW-1:0] src_root, root_in;
      logic [VW-1:0] src_rest;
      if (k == 0) begin : g_first
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_rest = v;
      end else begin : g_next
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_rest = rest_ff[k-1];
      end
      // bring down the next bit pair and try the trial subtrahend
      always_comb begin
         rem_t = {src_rem[RW-1:0], src_rest[VW-1 -: 2]};
         trial = {src_root, 2'b01};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {src_root[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {src_root[RW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rest_ff[k] <= {src_rest[VW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[RW-1];
endmodule
`default_nettype wire

// ===== hdl/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_div #(
   parameter int DW = 32,
   parameter int SW = 18
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [SW-1:0] divisor,
   output logic [DW-1:0]      quotient
);
   logic [SW-1:0] rem_ff [DW];
   logic [DW-1:0] quo_ff [DW];
   logic [DW-1:0] dvd_ff [DW];
   logic [SW-1:0] dsr_ff [DW];

   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic [SW-1:0] src_rem, src_dsr, rem_in;
      logic [DW-1:0] src_quo, src_dvd;
      logic [SW:0]   t;
      logic          qbit;
      if (k == 0) begin : g_first
         assign src_rem = '0;
         assign src_quo = '0;
         assign src_dvd = dividend;
         assign src_dsr = divisor;
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_quo = quo_ff[k-1];
         assign src_dvd = dvd_ff[k-1];
         assign src_dsr = dsr_ff[k-1];
      end
      // shift in one dividend bit, subtract if it fits
      always_comb begin
         t    = {src_rem, src_dvd[DW-1]};
         qbit = (t >= {1'b0, src_dsr});
         rem_in = qbit ? SW'(t - {1'b0, src_dsr}) : t[SW-1:0];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= {src_quo[DW-2:0], qbit};
            dvd_ff[k] <= {src_dvd[DW-2:0], 1'b0};
            dsr_ff[k] <= src_dsr;
         end
      end
   end

   assign quotient = quo_ff[DW-1];
endmodule
`default_nettype wire

// ===== hdl/rotation_matrix_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix to quaternion, Shepperd's four branches, fixed point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | m00 .. m22
//  rsp_    | out       | rsp_valid/rsp_stall  | qx qy qz qw branch_taken degenerate
//
//  One matrix per cycle while no result waits stalled. The pipeline is a front
//  stage, the square root pipeline (one root bit per stage) and the divider
//  pipeline (one quotient bit per stage), then the output register.
//  Reset clears the valid bits only. A stalled result freezes the whole
//  pipeline, so req_stall follows rsp_stall while a result is waiting.
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_quaternion_unit
   import rmq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 14
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_m00, req_m01, req_m02,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_m10, req_m11, req_m12,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_m20, req_m21, req_m22,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_qx, rsp_qy, rsp_qz, rsp_qw,
   output logic [1:0]                          rsp_branch_taken,
   output logic                                rsp_degenerate
);
   localparam int W   = SAMPLE_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int AW  = ((W > F + 1) ? W : F + 1) + 3;
   localparam int UW  = AW - 1;
   localparam int VW0 = UW + F;
   localparam int VW  = VW0 + (VW0 % 2);
   localparam int RW  = VW / 2;
   localparam int SW  = RW + 1;
   localparam int NW  = W + 1;
   localparam int DW  = NW + F + 1;
   localparam int CW  = RW + W;

   localparam logic [DW-1:0] SMAX_Q  = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [DW-1:0] SMIN_Q  = SMAX_Q + DW'(1);
   localparam logic [CW-1:0] SMAX_C  = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [W-1:0]  SMAX_W  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  SMIN_W  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  ONE_SAT = (F >= W - 1) ? SMAX_W : (W'(1) << F);

   logic en;
   logic front_vld_ff;
   logic vld_ff [RW+DW];
   logic rsp_valid_ff;

   // whole pipeline moves unless a result waits
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // front stage
   logic [UW-1:0] arg_f;
   logic [NW-1:0] n0_f, n1_f, n2_f;
   logic [2:0]    neg_f;
   logic [1:0]    br_f;

   rmq_front #(.W(W), .F(F), .AW(AW), .UW(UW), .NW(NW)) u_front (
      .clock(clock), .en(en),
      .m00(req_m00), .m01(req_m01), .m02(req_m02),
      .m10(req_m10), .m11(req_m11), .m12(req_m12),
      .m20(req_m20), .m21(req_m21), .m22(req_m22),
      .arg_ff(arg_f), .n0_ff(n0_f), .n1_ff(n1_f), .n2_ff(n2_f),
      .neg_ff(neg_f), .br_ff(br_f)
   );

   // square root of arg * 2^F
   logic [VW-1:0] sq_v;
   logic [RW-1:0] root;
   assign sq_v = VW'({arg_f, {F{1'b0}}});

   rmq_sqrt #(.VW(VW), .RW(RW)) u_sqrt (
      .clock(clock), .en(en), .v(sq_v), .root(root)
   );

   // side data alongside the root pipeline
   logic [NW-1:0] sn0_ff [RW], sn1_ff [RW], sn2_ff [RW];
   logic [2:0]    sneg_ff [RW];
   logic [1:0]    sbr_ff  [RW];
   always_ff @(posedge clock) begin
      if (en) begin
         sn0_ff[0] <= n0_f; sn1_ff[0] <= n1_f; sn2_ff[0] <= n2_f;
         sneg_ff[0] <= neg_f; sbr_ff[0] <= br_f;
         for (int k = 1; k < RW; k++) begin
            sn0_ff[k]  <= sn0_ff[k-1];
            sn1_ff[k]  <= sn1_ff[k-1];
            sn2_ff[k]  <= sn2_ff[k-1];
            sneg_ff[k] <= sneg_ff[k-1];
            sbr_ff[k]  <= sbr_ff[k-1];
         end
      end
   end

   // dividends: |n| * 2^F + s/2, with s = 2r
   logic [SW-1:0] s_val;
   logic [DW-1:0] dd0, dd1, dd2, qo0, qo1, qo2;
   assign s_val = {root, 1'b0};
   assign dd0 = DW'({sn0_ff[RW-1], {F{1'b0}}}) + DW'(root);
   assign dd1 = DW'({sn1_ff[RW-1], {F{1'b0}}}) + DW'(root);
   assign dd2 = DW'({sn2_ff[RW-1], {F{1'b0}}}) + DW'(root);

   rmq_div #(.DW(DW), .SW(SW)) u_div0 (
      .clock(clock), .en(en), .dividend(dd0), .divisor(s_val), .quotient(qo0));
   rmq_div #(.DW(DW), .SW(SW)) u_div1 (
      .clock(clock), .en(en), .dividend(dd1), .divisor(s_val), .quotient(qo1));
   rmq_div #(.DW(DW), .SW(SW)) u_div2 (
      .clock(clock), .en(en), .dividend(dd2), .divisor(s_val), .quotient(qo2));

   // side data alongside the divider pipeline
   logic [RW-1:0] droot_ff [DW];
   logic [2:0]    dneg_ff  [DW];
   logic [1:0]    dbr_ff   [DW];
   always_ff @(posedge clock) begin
      if (en) begin
         droot_ff[0] <= root; dneg_ff[0] <= sneg_ff[RW-1]; dbr_ff[0] <= sbr_ff[RW-1];
         for (int k = 1; k < DW; k++) begin
            droot_ff[k] <= droot_ff[k-1];
            dneg_ff[k]  <= dneg_ff[k-1];
            dbr_ff[k]   <= dbr_ff[k-1];
         end
      end
   end

   // signed saturation of a quotient
   function automatic logic [W-1:0] sat_q(input logic [DW-1:0] q, input logic neg);
      logic [DW-1:0] nq;
      begin
         nq = -q;
         if (neg) sat_q = (q > SMIN_Q) ? SMIN_W : nq[W-1:0];
         else     sat_q = (q > SMAX_Q) ? SMAX_W : q[W-1:0];
      end
   endfunction

   // final assembly
   logic [W-1:0] c0, c1, c2, quarter;
   logic [W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic [RW-1:0] r_end;
   logic [CW-1:0] qtr_c;
   logic          deg_in;
   logic [1:0]    br_end;
   always_comb begin
      r_end  = droot_ff[DW-1];
      br_end = dbr_ff[DW-1];
      deg_in = (r_end == '0);
      qtr_c  = CW'(r_end >> 1);
      quarter = (qtr_c > SMAX_C) ? SMAX_W : qtr_c[W-1:0];
      c0 = sat_q(qo0, dneg_ff[DW-1][0]);
      c1 = sat_q(qo1, dneg_ff[DW-1][1]);
      c2 = sat_q(qo2, dneg_ff[DW-1][2]);
      unique case (br_end)
         BR_TRACE: begin qx_in = c0; qy_in = c1; qz_in = c2; qw_in = quarter; end
         BR_M00:   begin qx_in = quarter; qy_in = c0; qz_in = c1; qw_in = c2; end
         BR_M11:   begin qx_in = c0; qy_in = quarter; qz_in = c1; qw_in = c2; end
         default:  begin qx_in = c0; qy_in = c1; qz_in = quarter; qw_in = c2; end
      endcase
      if (deg_in) begin
         qx_in = '0; qy_in = '0; qz_in = '0; qw_in = ONE_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_qx           <= qx_in;
         rsp_qy           <= qy_in;
         rsp_qz           <= qz_in;
         rsp_qw           <= qw_in;
         rsp_branch_taken <= br_end;
         rsp_degenerate   <= deg_in;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < RW + DW; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         front_vld_ff <= req_valid;
         vld_ff[0]    <= front_vld_ff;
         for (int k = 1; k < RW + DW; k++) vld_ff[k] <= vld_ff[k-1];
         rsp_valid_ff <= vld_ff[RW+DW-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and self-checking for the rotation matrix to quaternion unit:
// directed corner matrices, then random matrices with and then without random
// idling on both channels, every transfer compared against an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top
   import rmq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW   = 16;
   localparam int FB   = 14;
   localparam int ONE  = 1 << FB;
   localparam longint SMAX = (1 << (SW - 1)) - 1;
   localparam longint SMIN = -SMAX - 1;
   localparam int TIMEOUT_CYCLES = 400000;

   typedef logic signed [SW-1:0] sample_type;
   typedef struct packed {
      sample_type qx, qy, qz, qw;
      logic [1:0] br;
      logic       degen;
   } quat_type;

   localparam sample_type ONE_S = sample_type'(ONE);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sample_type m [9];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sample_type rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   logic [1:0] rsp_branch_taken;
   logic rsp_degenerate;

   quat_type quat_pending [$];
   int    fail_count  = 0;
   int    sent_count  = 0;
   int    got_count   = 0;
   int    degen_count = 0;
   int    br_count [4] = '{0, 0, 0, 0};
   int    cycle_count = 0;
   int    stall_left  = 0;
   bit    idle_en     = 1'b1;

   initial for (int i = 0; i < 9; i++) m[i] = '0;

   always #4 clock = ~clock;

   rotation_matrix_to_quaternion_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m00(m[0]), .req_m01(m[1]), .req_m02(m[2]),
      .req_m10(m[3]), .req_m11(m[4]), .req_m12(m[5]),
      .req_m20(m[6]), .req_m21(m[7]), .req_m22(m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_qx(rsp_qx), .rsp_qy(rsp_qy), .rsp_qz(rsp_qz), .rsp_qw(rsp_qw),
      .rsp_branch_taken(rsp_branch_taken), .rsp_degenerate(rsp_degenerate)
   );

   // integer square root, bit by bit
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clip(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   // rounded n/s in Q format, halves away from zero
   function automatic longint scaled_div(longint n, longint unsigned s);
      longint unsigned mag, q;
      mag = (n < 0) ? longint'(-n) : longint'(n);
      q = ((mag << FB) + (s >> 1)) / s;
      if (n < 0) return (q > SMAX + 1) ? SMIN : -longint'(q);
      return (q > SMAX) ? SMAX : longint'(q);
   endfunction

   function automatic quat_type predict_quat(sample_type a [9]);
      longint e [9];
      longint tr, arg, quarter;
      longint unsigned s;
      quat_type q;
      for (int i = 0; i < 9; i++) e[i] = a[i];
      tr = e[0] + e[4] + e[8];
      if (tr > 0) begin
         q.br = BR_TRACE; arg = tr + ONE;
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         q.br = BR_M00; arg = ONE + e[0] - e[4] - e[8];
      end else if (e[4] > e[8]) begin
         q.br = BR_M11; arg = ONE + e[4] - e[0] - e[8];
      end else begin
         q.br = BR_M22; arg = ONE + e[8] - e[0] - e[4];
      end
      if (arg < 0) arg = 0;
      s = 2 * int_sqrt(longint'(arg) << FB);
      q.degen = (s == 0);
      if (s == 0) begin
         q.qx = '0; q.qy = '0; q.qz = '0; q.qw = sample_type'(clip(ONE));
      end else begin
         quarter = clip(longint'(s >> 2));
         case (q.br)
            BR_TRACE: begin
               q.qx = sample_type'(scaled_div(e[7] - e[5], s));
               q.qy = sample_type'(scaled_div(e[2] - e[6], s));
               q.qz = sample_type'(scaled_div(e[3] - e[1], s));
               q.qw = sample_type'(quarter);
            end
            BR_M00: begin
               q.qx = sample_type'(quarter);
               q.qy = sample_type'(scaled_div(e[1] + e[3], s));
               q.qz = sample_type'(scaled_div(e[2] + e[6], s));
               q.qw = sample_type'(scaled_div(e[7] - e[5], s));
            end
            BR_M11: begin
               q.qx = sample_type'(scaled_div(e[1] + e[3], s));
               q.qy = sample_type'(quarter);
               q.qz = sample_type'(scaled_div(e[5] + e[7], s));
               q.qw = sample_type'(scaled_div(e[2] - e[6], s));
            end
            default: begin
               q.qx = sample_type'(scaled_div(e[2] + e[6], s));
               q.qy = sample_type'(scaled_div(e[5] + e[7], s));
               q.qz = sample_type'(quarter);
               q.qw = sample_type'(scaled_div(e[3] - e[1], s));
            end
         endcase
      end
      return q;
   endfunction

   // present one matrix, hold until the transfer, maybe idle afterwards
   task automatic send_matrix(sample_type a [9]);
      for (int i = 0; i < 9; i++) m[i] <= a[i];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      quat_pending.push_back(predict_quat(a));
      sent_count++;
      @(negedge clock);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   task automatic send_diag(sample_type d0, sample_type d1, sample_type d2);
      sample_type a [9];
      for (int i = 0; i < 9; i++) a[i] = sample_type'($urandom);
      a[0] = d0; a[4] = d1; a[8] = d2;
      send_matrix(a);
   endtask

   // random stall bursts on the result side
   always @(negedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15);
         rsp_stall <= 1'b1;
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      quat_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_count <= got_count + 1;
         if (quat_pending.size() == 0) begin
            $error("unexpected result transfer");
            fail_count <= fail_count + 1;
         end else begin
            want = quat_pending.pop_front();
            if (rsp_degenerate) degen_count <= degen_count + 1;
            br_count[rsp_branch_taken] <= br_count[rsp_branch_taken] + 1;
            if (rsp_qx !== want.qx) begin
               $error("qx expected %0d actual %0d", want.qx, rsp_qx);
               fail_count <= fail_count + 1;
            end
            if (rsp_qy !== want.qy) begin
               $error("qy expected %0d actual %0d", want.qy, rsp_qy);
               fail_count <= fail_count + 1;
            end
            if (rsp_qz !== want.qz) begin
               $error("qz expected %0d actual %0d", want.qz, rsp_qz);
               fail_count <= fail_count + 1;
            end
            if (rsp_qw !== want.qw) begin
               $error("qw expected %0d actual %0d", want.qw, rsp_qw);
               fail_count <= fail_count + 1;
            end
            if (rsp_branch_taken !== want.br) begin
               $error("branch_taken expected %0d actual %0d", want.br, rsp_branch_taken);
               fail_count <= fail_count + 1;
            end
            if (rsp_degenerate !== want.degen) begin
               $error("degenerate expected %0d actual %0d", want.degen, rsp_degenerate);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // identity, extremes, ties and every branch
   task automatic test_directed();
      sample_type a [9];
      sample_type mx, mn;
      mx = sample_type'(SMAX);
      mn = sample_type'(SMIN);
      for (int i = 0; i < 9; i++) a[i] = '0;
      a[0] = ONE_S; a[4] = ONE_S; a[8] = ONE_S;
      send_matrix(a);
      for (int i = 0; i < 9; i++) a[i] = mx;
      send_matrix(a);
      for (int i = 0; i < 9; i++) a[i] = mn;
      send_matrix(a);
      for (int i = 0; i < 9; i++) a[i] = (i % 2) ? mn : mx;
      send_matrix(a);
      for (int i = 0; i < 9; i++) a[i] = (i % 2) ? mx : mn;
      send_matrix(a);
      // zero matrix: trace not positive, equal diagonal falls to m22 branch
      for (int i = 0; i < 9; i++) a[i] = '0;
      send_matrix(a);
      // diagonals of 180 degree rotations pick each diagonal branch
      send_diag(ONE_S, -ONE_S, -ONE_S);
      send_diag(-ONE_S, ONE_S, -ONE_S);
      send_diag(-ONE_S, -ONE_S, ONE_S);
      // ties on the diagonal
      send_diag(-ONE_S, -ONE_S, sample_type'(1 - ONE));
      send_diag(sample_type'(-100), sample_type'(-100), sample_type'(-200));
      send_diag(sample_type'(-100), sample_type'(-200), sample_type'(-100));
      send_diag(sample_type'(-200), sample_type'(-100), sample_type'(-100));
      // negative diagonal entries, argument stays positive
      send_diag(mn, mn, mn);
      send_diag(-ONE_S, -ONE_S, -ONE_S);
      send_diag(mn, mn, -ONE_S);
      send_diag('0, '0, -ONE_S);
      // trace exactly zero and just positive, then extreme diagonals
      send_diag(ONE_S, -ONE_S, '0);
      send_diag(ONE_S, -ONE_S, sample_type'(1));
      send_diag(mx, mx, mx);
      send_diag(mx, mn, mn);
   endtask

   // random matrices: mostly near-rotation values, some fully random
   task automatic test_random(int count);
      sample_type a [9];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++) begin
            case ($urandom_range(0, 3))
               0: a[i] = sample_type'($urandom);
               1: a[i] = sample_type'($urandom_range(0, 2 * ONE) - ONE);
               2: a[i] = sample_type'($urandom_range(0, 64) - 32);
               default: a[i] = sample_type'($urandom_range(0, 2 * ONE) - ONE);
            endcase
         end
         send_matrix(a);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(850);
      idle_en = 1'b0;
      test_random(150);
      req_valid <= 1'b0;
      while (quat_pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d matrices, checked %0d quaternions, %0d degenerate",
               sent_count, got_count, degen_count);
      $display("branches trace/m00/m11/m22: %0d/%0d/%0d/%0d",
               br_count[0], br_count[1], br_count[2], br_count[3]);
      if (fail_count == 0 && quat_pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire
